// File: src/wgf_pkg.sv
// ----------------------------------------------------------------------------
// wgf_pkg
// Shared types and constants for the streaming 3x3 grey-level filter.
// ----------------------------------------------------------------------------
package wgf_pkg;

  // Field widths of the item and register formats.
  localparam int PIX_W      = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Default line store depth.
  localparam int MAX_WIDTH_DEF = 2048;

  // Kernel sums fit in 12 bits: 9 * 255 for the box, 16 * 255 for the Gaussian.
  localparam int SUM_W = 12;

  // Division by nine as a multiply by ceil(2^16 / 9) and a shift by 16.
  // This is exact for every sum up to 9 * 255.
  localparam int            RECIP_W  = 13;
  localparam int            RECIP_SH = 16;
  localparam logic [12:0]   RECIP9   = 13'd7282;

  // Depth of the job queue between front and back. Must be a power of two.
  localparam int QUEUE_DEPTH = 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd2;

  // Filter selection. The fourth code passes the centre pixel through.
  typedef enum logic [1:0] {
    MODE_BOX     = 2'd0,
    MODE_GAUSS   = 2'd1,
    MODE_LAPLACE = 2'd2,
    MODE_PASS    = 2'd3
  } filter_mode_t;

  // One job handed from the front to the back. The line store address
  // travels next to it, since its width follows the depth parameter.
  typedef struct packed {
    logic [PIX_W-1:0] px;      // pixel shifted into the window
    logic             emit;    // this job releases one result
    logic             border;  // released result lies on the frame border
    logic             last;    // released result is the last of the frame
  } job_t;

  // Front status, watched by the top level checks.
  typedef struct packed {
    logic [FW_W-1:0] pending;  // items taken whose result is still owed
    logic [FW_W-1:0] width;    // effective row width
  } front_stat_t;

endpackage

// File: src/wgf_if.sv
// ----------------------------------------------------------------------------
// wgf_if
// Valid/ready channels of the 3x3 filter: pixel input, result output and
// register writes.
// ----------------------------------------------------------------------------

// Pixel or flush item going into the filter.
interface wgf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [wgf_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

// Filtered pixel leaving the filter.
interface wgf_out_if;
  logic                      valid;
  logic                      ready;
  logic [wgf_pkg::PIX_W-1:0] pixel_out;
  logic                      last_of_frame;

  modport source (output valid, output pixel_out, output last_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input last_of_frame, output ready);
endinterface

// Register write channel.
interface wgf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wgf_pkg::CFG_IDX_W-1:0]  index;
  logic [wgf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/window_3x3_gray_filter_core.sv
// ----------------------------------------------------------------------------
// window_3x3_gray_filter_core
// Streaming 3x3 grey-level filter (box mean, 1-2-1 Gaussian, Laplacian).
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one item per clock while the job queue is
// not full, and filtered pixels leave in raster order one row plus one pixel
// behind; after the last pixel of a frame, send frame_width+1 flush items to
// drain it. The sustained rate of one item per clock is set by the two line
// stores, each doing one read and one write per item. The job behind a result
// is registered in turn in the queue entry, the store read stage, the window,
// the sum registers and the output register. The input keeps accepting while
// a result waits at the output, until a four-entry job queue is full. Border
// pixels pass unchanged. The line stores are not cleared by reset. Write
// registers only while the block is idle; a width or height write restarts the frame position.
module window_3x3_gray_filter_core #(
  parameter int MAX_WIDTH = wgf_pkg::MAX_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  wgf_in_if.sink    in_ch,
  wgf_out_if.source out_ch,
  wgf_cfg_if.sink   cfg_ch
);
  import wgf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic          q_push, q_full, q_pop, q_valid;
  job_t          push_job, head_job;
  logic [AW-1:0] push_addr, head_addr;
  filter_mode_t  mode;
  front_stat_t   stat;

  // Item intake, registers and frame counters.
  wgf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_full    (q_full),
    .push      (q_push),
    .push_job  (push_job),
    .push_addr (push_addr),
    .mode      (mode),
    .stat      (stat)
  );

  // Job queue between intake and filter pipeline.
  wgf_queue #(.AW(AW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .push_addr  (push_addr),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job),
    .head_addr  (head_addr)
  );

  // Line stores, window and filter arithmetic.
  wgf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_addr  (head_addr),
    .pop     (q_pop),
    .mode    (mode),
    .out_ch  (out_ch)
  );

  // A width or height write restarts the frame with nothing owed.
  a_geom_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && cfg_ch.ready &&
    (cfg_ch.index == CFG_IDX_WIDTH || cfg_ch.index == CFG_IDX_HEIGHT)
    |=> stat.pending == '0)
    else $error("pending count not cleared by geometry write");

  // No more than one row of results is ever owed.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pending <= stat.width)
    else $error("pending count exceeds row width");

  // A flush item with nothing owed must not reach the pipeline.
  a_flush_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.kind && stat.pending == '0 |-> !q_push)
    else $error("idle flush item queued");

  // The front never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job queue overflow");

endmodule

// File: src/wgf_front.sv
// ----------------------------------------------------------------------------
// wgf_front
// Accepts items, holds the registers and frame counters, and turns each item
// into a job for the back end: pixel or zero to shift in, plus the border and
// last flags of the result it releases.
// ----------------------------------------------------------------------------
module wgf_front #(
  parameter int MAX_WIDTH = wgf_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  wgf_in_if.sink                       in_ch,
  wgf_cfg_if.sink                      cfg_ch,
  input  logic                         q_full,
  output logic                         push,
  output wgf_pkg::job_t                push_job,
  output logic [$clog2(MAX_WIDTH)-1:0] push_addr,
  output wgf_pkg::filter_mode_t        mode,
  output wgf_pkg::front_stat_t         stat
);
  import wgf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = ((AW > FW_W) ? AW : FW_W) + 1;

  filter_mode_t    mode_r;
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic [AW-1:0]   col_r, col_nxt;
  logic [FW_W-1:0] ocol_r, ocol_nxt;
  logic [FH_W-1:0] row_r, row_nxt;
  logic [FW_W-1:0] pend_r, pend_nxt;

  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic [CW-1:0]   col_inc;
  logic [FW_W:0]   ocol_inc;
  logic [FH_W:0]   row_inc;
  logic            accept, live, emit, cfg_wr, geom_wr;

  // Effective geometry: zero acts as one, widths past the stores are clipped.
  always_comb begin
    if (fw_r == '0) begin
      w_eff = FW_W'(1);
    end else if ({20'd0, fw_r} > 32'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = fw_r;
    end
    h_eff = (fh_r == '0) ? FH_W'(1) : fh_r;
  end

  // Handshake and classification. A flush with nothing owed is dropped.
  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;
  assign live   = in_ch.kind ? (pend_r != '0) : 1'b1;
  assign emit   = in_ch.kind ? 1'b1 : (pend_r >= w_eff);
  assign push   = accept && live;
  assign cfg_wr  = cfg_ch.valid && cfg_ch.ready;
  assign geom_wr = cfg_wr && (cfg_ch.index == CFG_IDX_WIDTH ||
                              cfg_ch.index == CFG_IDX_HEIGHT);

  // Job fields for the back end.
  always_comb begin
    push_job.px     = in_ch.kind ? '0 : in_ch.pixel_in;
    push_job.emit   = emit;
    push_job.border = (row_r == '0) || (row_r >= h_eff - FH_W'(1)) ||
                      (ocol_r == '0) || (ocol_r >= w_eff - FW_W'(1));
    push_job.last   = (row_r >= h_eff - FH_W'(1)) && (ocol_r >= w_eff - FW_W'(1));
    push_addr       = col_r;
  end

  // Counter updates: line store address, output position and owed results.
  always_comb begin
    col_inc  = CW'(col_r) + CW'(1);
    ocol_inc = {1'b0, ocol_r} + (FW_W+1)'(1);
    row_inc  = {1'b0, row_r} + (FH_W+1)'(1);
    col_nxt  = col_r;
    ocol_nxt = ocol_r;
    row_nxt  = row_r;
    pend_nxt = pend_r;
    if (geom_wr) begin
      col_nxt  = '0;
      ocol_nxt = '0;
      row_nxt  = '0;
      pend_nxt = '0;
    end else if (push) begin
      col_nxt = (col_inc >= CW'(w_eff)) ? '0 : col_inc[AW-1:0];
      if (emit) begin
        if (ocol_inc >= {1'b0, w_eff}) begin
          ocol_nxt = '0;
          row_nxt  = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[FH_W-1:0];
        end else begin
          ocol_nxt = ocol_inc[FW_W-1:0];
        end
      end
      if (in_ch.kind) begin
        pend_nxt = pend_r - FW_W'(1);
      end else if (!emit) begin
        pend_nxt = pend_r + FW_W'(1);
      end
    end
  end

  // Registers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BOX;
      fw_r   <= FW_W'(640);
      fh_r   <= FH_W'(480);
      col_r  <= '0;
      ocol_r <= '0;
      row_r  <= '0;
      pend_r <= '0;
    end else begin
      col_r  <= col_nxt;
      ocol_r <= ocol_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          CFG_IDX_MODE:   mode_r <= filter_mode_t'(cfg_ch.data[1:0]);
          CFG_IDX_WIDTH:  fw_r   <= cfg_ch.data[FW_W-1:0];
          CFG_IDX_HEIGHT: fh_r   <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  assign mode         = mode_r;
  assign stat.pending = pend_r;
  assign stat.width   = w_eff;

endmodule

// File: src/wgf_queue.sv
// ----------------------------------------------------------------------------
// wgf_queue
// Short job queue that decouples the front end from the filter pipeline.
// ----------------------------------------------------------------------------
module wgf_queue #(
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wgf_pkg::job_t push_job,
  input  logic [AW-1:0] push_addr,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output wgf_pkg::job_t head_job,
  output logic [AW-1:0] head_addr
);
  import wgf_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          job_r  [QUEUE_DEPTH];
  logic [AW-1:0] addr_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;
  assign head_job   = job_r[rd_ptr_r];
  assign head_addr  = addr_r[rd_ptr_r];

  // Occupancy.
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  // Pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      job_r[wr_ptr_r]  <= push_job;
      addr_r[wr_ptr_r] <= push_addr;
    end
  end

endmodule

// File: src/wgf_back.sv
// ----------------------------------------------------------------------------
// wgf_back
// Filter pipeline: line store read, window shift and store write-back,
// kernel sums, final scaling and clamping, and the output register.
// ----------------------------------------------------------------------------
module wgf_back #(
  parameter int MAX_WIDTH = wgf_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  wgf_pkg::job_t                q_job,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
  output logic                         pop,
  input  wgf_pkg::filter_mode_t        mode,
  wgf_out_if.source                    out_ch
);
  import wgf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  // Line stores.
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic             adv;
  logic             a_valid_r, b_valid_r, c_valid_r, out_valid_r;
  job_t             a_job_r, b_job_r, c_job_r;
  logic [AW-1:0]    a_addr_r;
  logic [PIX_W-1:0] up_q_r, mid_q_r, byp_up_r, byp_mid_r;
  logic             byp_r;
  logic [PIX_W-1:0] up_rd, mid_rd;
  logic [PIX_W-1:0] win_r [3][3];

  logic [SUM_W-1:0]        box_sum, gauss_sum;
  logic signed [SUM_W-1:0] lap;
  logic [SUM_W-1:0]        c_sum_r;
  logic signed [SUM_W-1:0] c_lap_r;
  logic [PIX_W-1:0]        c_center_r;
  logic [SUM_W+RECIP_W-1:0] prod9;
  logic [PIX_W-1:0]        result;
  logic [PIX_W-1:0]        out_pixel_r;
  logic                    out_last_r;

  // The whole pipeline moves when the output register is free or drained.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && q_valid;

  // Read port: the job leaving the queue reads both stores. When the job
  // just ahead writes the same entry in that cycle (one-pixel rows), the
  // written values are captured instead.
  always_ff @(posedge clk) begin
    if (pop) begin
      up_q_r  <= upper_mem[q_addr];
      mid_q_r <= middle_mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byp_r     <= a_valid_r && (a_addr_r == q_addr);
      byp_up_r  <= mid_rd;
      byp_mid_r <= a_job_r.px;
    end
  end

  assign up_rd  = byp_r ? byp_up_r  : up_q_r;
  assign mid_rd = byp_r ? byp_mid_r : mid_q_r;

  // Write port: each row moves up one store as the new pixel arrives.
  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      upper_mem[a_addr_r]  <= mid_rd;
      middle_mem[a_addr_r] <= a_job_r.px;
    end
  end

  // Window shift, one column per job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else if (adv && a_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= up_rd;
      win_r[1][2] <= mid_rd;
      win_r[2][2] <= a_job_r.px;
    end
  end

  // Kernel sums over the current window.
  always_comb begin
    box_sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        box_sum = box_sum + SUM_W'(win_r[r][k]);
      end
    end
    gauss_sum = SUM_W'(win_r[0][0]) + SUM_W'(win_r[0][2]) +
                SUM_W'(win_r[2][0]) + SUM_W'(win_r[2][2]) +
                ((SUM_W'(win_r[0][1]) + SUM_W'(win_r[1][0]) +
                  SUM_W'(win_r[1][2]) + SUM_W'(win_r[2][1])) << 1) +
                (SUM_W'(win_r[1][1]) << 2);
    lap = $signed(SUM_W'(win_r[1][1]) << 2) -
          $signed(SUM_W'(win_r[0][1])) - $signed(SUM_W'(win_r[1][0])) -
          $signed(SUM_W'(win_r[1][2])) - $signed(SUM_W'(win_r[2][1]));
  end

  // Final scaling or clamping of the registered sums.
  assign prod9 = c_sum_r * RECIP9;

  always_comb begin
    unique case (mode)
      MODE_BOX:   result = prod9[RECIP_SH+PIX_W-1:RECIP_SH];
      MODE_GAUSS: result = c_sum_r[PIX_W+3:4];
      MODE_LAPLACE: begin
        if (c_lap_r[SUM_W-1]) begin
          result = '0;
        end else if (c_lap_r[SUM_W-2:PIX_W] != '0) begin
          result = '1;
        end else begin
          result = c_lap_r[PIX_W-1:0];
        end
      end
      MODE_PASS:  result = c_center_r;
    endcase
    if (c_job_r.border) result = c_center_r;
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= q_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r && c_job_r.emit;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_job_r     <= q_job;
      a_addr_r    <= q_addr;
      b_job_r     <= a_job_r;
      c_job_r     <= b_job_r;
      c_sum_r     <= (mode == MODE_GAUSS) ? gauss_sum : box_sum;
      c_lap_r     <= lap;
      c_center_r  <= win_r[1][1];
      out_pixel_r <= result;
      out_last_r  <= c_job_r.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_out     = out_pixel_r;
  assign out_ch.last_of_frame = out_last_r;

endmodule

// File: verif/wgf_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgf_tb_pkg
// Item codes shared by the stimulus side and the checker of the 3x3 filter
// testbench.
// ----------------------------------------------------------------------------
package wgf_tb_pkg;

  // Meaning of the kind field of an input item.
  typedef enum logic {
    ITEM_PIXEL = 1'b0,
    ITEM_FLUSH = 1'b1
  } item_kind_t;

endpackage

// File: verif/wgf_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgf_filter_checker
// Watches the pixel, result and register channels of the 3x3 filter. It
// keeps its own copy of the line stores, window and frame position, works
// out the filtered pixel that each accepted item releases, and compares
// every accepted result field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module wgf_filter_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_kind,
  input  logic [wgf_pkg::PIX_W-1:0]      in_pixel,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [wgf_pkg::PIX_W-1:0]      out_pixel,
  input  logic                           out_last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [wgf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wgf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             results_owed,
  output int                             results_checked
);
  import wgf_pkg::*;
  import wgf_tb_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH_DEF;
  localparam int SHOWN_MAX  = 40;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } filt_result_t;

  // Predicted state of the filter.
  logic [PIX_W-1:0] upper_line  [LINE_DEPTH];
  logic [PIX_W-1:0] middle_line [LINE_DEPTH];
  logic [PIX_W-1:0] win [3][3];
  int unsigned      wr_col;
  int unsigned      res_row;
  int unsigned      res_col;
  int unsigned      owed;
  filter_mode_t     mode_q;
  logic [FW_W-1:0]  width_q;
  logic [FH_W-1:0]  height_q;

  // Filtered pixels released but not yet seen at the output, oldest first.
  filt_result_t filtered_q [$];

  // Row length and frame height after the out-of-range rules.
  function automatic int unsigned row_len();
    if (width_q == '0) return 1;
    if (width_q > LINE_DEPTH) return LINE_DEPTH;
    return width_q;
  endfunction

  function automatic int unsigned frame_rows();
    return (height_q == '0) ? 1 : height_q;
  endfunction

  // Report one failure, keeping the log short when the block is badly off.
  task automatic note_failure(input string what, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= SHOWN_MAX) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Shift one column into the window and rotate the line stores.
  task automatic shift_in(input logic [PIX_W-1:0] px, input int unsigned w);
    int unsigned a;
    a = (wr_col >= w) ? 0 : wr_col;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_line[a];
    win[1][2] = middle_line[a];
    win[2][2] = px;
    upper_line[a] = middle_line[a];
    middle_line[a] = px;
    a++;
    wr_col = (a >= w) ? 0 : a;
  endtask

  // Kernel applied to the current window.
  function automatic logic [PIX_W-1:0] kernel_value();
    int acc;
    int c;
    c = int'(win[1][1]);
    case (mode_q)
      MODE_BOX: begin
        acc = 0;
        for (int r = 0; r < 3; r++) begin
          for (int k = 0; k < 3; k++) acc += int'(win[r][k]);
        end
        acc = acc / 9;
      end
      MODE_GAUSS: begin
        acc = int'(win[0][0]) + int'(win[0][2]) + int'(win[2][0]) + int'(win[2][2])
            + 2 * (int'(win[0][1]) + int'(win[1][0]) + int'(win[1][2]) + int'(win[2][1]))
            + 4 * c;
        acc = acc / 16;
      end
      MODE_LAPLACE: begin
        acc = 4 * c - int'(win[0][1]) - int'(win[1][0]) - int'(win[1][2]) - int'(win[2][1]);
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
      end
      default: acc = c;
    endcase
    return acc[PIX_W-1:0];
  endfunction

  // Release the result at the current output position.
  task automatic release_one(input int unsigned w);
    int unsigned  h;
    bit           on_border;
    filt_result_t res;
    h = frame_rows();
    on_border = (res_row == 0) || (res_row >= h - 1) || (res_col == 0) || (res_col >= w - 1);
    res.pixel = on_border ? win[1][1] : kernel_value();
    res.last  = (res_row >= h - 1) && (res_col >= w - 1);
    filtered_q.push_back(res);
    res_col++;
    if (res_col >= w) begin
      res_col = 0;
      res_row++;
      if (res_row >= h) res_row = 0;
    end
    owed--;
  endtask

  // A geometry write restarts the frame position.
  task automatic restart_frame();
    wr_col  = 0;
    res_row = 0;
    res_col = 0;
    owed    = 0;
  endtask

  // Follow every handshake at the rising edge.
  always @(posedge clk) begin
    filt_result_t want;
    int unsigned  w;
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) win[r][k] = '0;
      end
      restart_frame();
      mode_q          = MODE_BOX;
      width_q         = FW_W'(640);
      height_q        = FH_W'(480);
      filtered_q.delete();
      fail_count      = 0;
      results_checked = 0;
      results_owed    = 0;
    end else begin
      // Compare the result leaving the block with the oldest one owed.
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOWN_MAX) begin
            $display("%0t: unexpected result, expected none, actual pixel %0d last %0d",
                     $time, out_pixel, out_last);
          end
        end else begin
          want = filtered_q.pop_front();
          results_checked++;
          if (want.pixel !== out_pixel) note_failure("pixel_out", want.pixel, out_pixel);
          if (want.last !== out_last) note_failure("last_of_frame", want.last, out_last);
        end
      end

      // Register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_MODE: mode_q = filter_mode_t'(cfg_data[1:0]);
          CFG_IDX_WIDTH: begin
            width_q = cfg_data[FW_W-1:0];
            restart_frame();
          end
          CFG_IDX_HEIGHT: begin
            height_q = cfg_data[FH_W-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end

      // Pixel and flush items.
      if (in_valid && in_ready) begin
        w = row_len();
        if (in_kind == ITEM_PIXEL) begin
          shift_in(in_pixel, w);
          owed++;
          if (owed > w) release_one(w);
        end else if (owed != 0) begin
          shift_in('0, w);
          release_one(w);
        end
      end

      results_owed = filtered_q.size();
    end
  end

endmodule

// File: verif/window_3x3_gray_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_3x3_gray_filter_core_tb
// Drives frames of grey pixels and flush items into the 3x3 filter under a
// series of filter modes and frame sizes, with random gaps on the input and
// random stalls on the output, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module window_3x3_gray_filter_core_tb;
  import wgf_pkg::*;
  import wgf_tb_pkg::*;

  // Index with no register behind it.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int CALM_ITEMS    = 150;

  typedef enum int {
    PAT_NOISE,
    PAT_EXTREME,
    PAT_FLAT,
    PAT_RAMP
  } pattern_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Clock with a 10 ns period.
  always #5 clk = ~clk;

  wgf_in_if  in_ch ();
  wgf_out_if out_ch ();
  wgf_cfg_if cfg_ch ();

  // Values driven onto the channels, changed at the falling edge.
  logic                  src_valid = 1'b0;
  item_kind_t            src_kind  = ITEM_PIXEL;
  logic [PIX_W-1:0]      src_pixel = '0;
  logic                  snk_ready = 1'b0;
  logic                  reg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  reg_index = '0;
  logic [CFG_DATA_W-1:0] reg_data  = '0;

  assign in_ch.valid    = src_valid;
  assign in_ch.kind     = src_kind;
  assign in_ch.pixel_in = src_pixel;
  assign out_ch.ready   = snk_ready;
  assign cfg_ch.valid   = reg_valid;
  assign cfg_ch.index   = reg_index;
  assign cfg_ch.data    = reg_data;

  bit          idle_on    = 1'b0;
  int unsigned stall_left = 0;
  int          quiet      = 0;
  int          items_sent = 0;
  int          frames_sent = 0;
  int          reg_writes = 0;
  int          fail_count;
  int          results_owed;
  int          results_checked;

  window_3x3_gray_filter_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  wgf_filter_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_kind         (in_ch.kind),
    .in_pixel        (in_ch.pixel_in),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_pixel       (out_ch.pixel_out),
    .out_last        (out_ch.last_of_frame),
    .cfg_valid       (cfg_ch.valid),
    .cfg_ready       (cfg_ch.ready),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .fail_count      (fail_count),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  // Output side: ready, with random stall bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      snk_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 9);
      snk_ready = 1'b0;
    end else begin
      snk_ready = 1'b1;
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, quiet);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one item, possibly after an idle burst, and wait until it is taken.
  task automatic put_item(input item_kind_t k, input logic [PIX_W-1:0] px);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      src_valid = 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(negedge clk);
    end
    src_valid = 1'b1;
    src_kind  = k;
    src_pixel = px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Flush items carry a pixel value that the block ignores.
  task automatic put_flushes(input int unsigned n);
    repeat (n) put_item(ITEM_FLUSH, PIX_W'($urandom_range(0, 255)));
  endtask

  // Hold the input until every released result has come out.
  task automatic wait_results();
    src_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // Bring the block to rest before a register write.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_valid = 1'b1;
    reg_index = idx;
    reg_data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    reg_valid = 1'b0;
    reg_writes++;
  endtask

  // Write the mode and, when asked, the geometry; unused data bits are random.
  task automatic configure(input filter_mode_t mode, input int unsigned w, input int unsigned h,
                           input bit geom);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom());
    data[1:0] = mode;
    write_reg(CFG_IDX_MODE, data);
    if (geom) begin
      data = CFG_DATA_W'($urandom());
      data[FW_W-1:0] = FW_W'(w);
      write_reg(CFG_IDX_WIDTH, data);
      write_reg(CFG_IDX_HEIGHT, CFG_DATA_W'(h));
    end
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input pattern_t pat, input logic [PIX_W-1:0] base,
                                                  input int unsigned i);
    case (pat)
      PAT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      PAT_FLAT:    return base;
      PAT_RAMP:    return base + PIX_W'(i * 3);
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One frame of w x h pixels. A rough frame may stop early or carry a few
  // flush items in its middle. The sender holds off until all released
  // results are out when pixel pause_at comes up.
  task automatic send_frame(input int unsigned w, input int unsigned h, input pattern_t pat,
                            input bit drain, input bit rough, input int unsigned pause_at);
    int unsigned      total;
    int unsigned      stop_at;
    int unsigned      flush_at;
    int unsigned      i;
    logic [PIX_W-1:0] base;
    total    = w * h;
    stop_at  = total;
    flush_at = total;
    base = ($urandom_range(0, 2) == 0) ? 8'hFF : PIX_W'($urandom_range(0, 255));
    if (rough) begin
      if ($urandom_range(0, 9) == 0) stop_at = $urandom_range(1, total);
      if ($urandom_range(0, 9) == 0) flush_at = $urandom_range(0, total - 1);
    end
    for (i = 0; i < stop_at; i++) begin
      if (i == pause_at) wait_results();
      if (i == flush_at) put_flushes($urandom_range(1, 3));
      put_item(ITEM_PIXEL, pick_pixel(pat, base, i));
    end
    if (drain) put_flushes(w + 1);
    frames_sent++;
  endtask

  initial begin
    filter_mode_t mode;
    int unsigned  cur_w;
    int unsigned  cur_h;
    int unsigned  nframes;
    int unsigned  total;
    int           random_end;
    int           calm_from;
    bit           geom;

    // Synchronous reset, released at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // A flush with nothing pending gives no result; the spare index is ignored.
    put_item(ITEM_FLUSH, 8'hA5);
    settle();
    write_reg(CFG_IDX_SPARE, 16'h5A5A);

    // Pass mode passes the centre; the sender waits mid-frame once.
    configure(MODE_PASS, 3, 3, 1'b1);
    send_frame(3, 3, PAT_EXTREME, 1'b1, 1'b0, 5);
    settle();

    // Zero width and zero height act as one.
    configure(MODE_LAPLACE, 0, 0, 1'b1);
    send_frame(1, 1, PAT_NOISE, 1'b1, 1'b0, 1);
    settle();

    // The tallest frame height, with idling; only four rows are sent.
    idle_on = 1'b1;
    configure(MODE_LAPLACE, 5, 65535, 1'b1);
    send_frame(5, 4, PAT_EXTREME, 1'b1, 1'b0, 20);
    settle();

    // Random phases of settings, each with a few frames.
    cur_w      = 5;
    cur_h      = 65535;
    random_end = items_sent + RANDOM_ITEMS;
    calm_from  = random_end - CALM_ITEMS;
    while (items_sent < random_end) begin
      idle_on = (items_sent < calm_from) && ($urandom_range(0, 3) != 0);
      mode = ($urandom_range(0, 9) == 0) ? MODE_PASS : filter_mode_t'($urandom_range(0, 2));
      geom = (cur_h > 64) || ($urandom_range(0, 3) != 0);
      if (geom) begin
        case ($urandom_range(0, 9))
          0:       cur_w = 1;
          1:       cur_w = 2;
          2, 3:    cur_w = $urandom_range(13, 32);
          default: cur_w = $urandom_range(3, 12);
        endcase
        cur_h = $urandom_range(1, 5);
      end
      configure(mode, cur_w, cur_h, geom);
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        total = cur_w * cur_h;
        send_frame(cur_w, cur_h, pattern_t'($urandom_range(0, 3)),
                   (f == nframes - 1) || ($urandom_range(0, 9) < 7), 1'b1,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : total);
      end
      if ($urandom_range(0, 4) == 0) begin
        settle();
        put_flushes($urandom_range(1, 2));
      end
      settle();
    end

    // Let any stray result show up before the verdict.
    idle_on = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d items in %0d frames with %0d register writes; %0d results checked.",
             items_sent, frames_sent, reg_writes, results_checked);
    $display("Modes box, Gaussian, Laplacian and pass; widths 1 to 32, heights 1 to 65535.");
    if (fail_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/wgf_pkg.sv
src/wgf_if.sv
src/wgf_front.sv
src/wgf_queue.sv
src/wgf_back.sv
src/window_3x3_gray_filter_core.sv
verif/wgf_tb_pkg.sv
verif/wgf_filter_checker.sv
verif/window_3x3_gray_filter_core_tb.sv
